// ===== hdl/obl_pkg.sv =====
// Shared types and constants for the ordered block list.
// No dependencies; every other source file uses this package.
package obl_pkg;

  localparam int ADDR_W = 31;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int ENT_W  = 2 * ADDR_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_INS_ADDR  = 3'd2,
    OP_INS_ASC   = 3'd3,
    OP_INS_DESC  = 3'd4,
    OP_REMOVE    = 3'd5,
    OP_COALESCE  = 3'd6,
    OP_CLEAR     = 3'd7
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [ADDR_W-1:0] addr_t;

endpackage

// ===== hdl/obl_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on obl_pkg for field widths.
interface obl_in_if;
  logic                      valid;
  logic                      ready;
  logic [obl_pkg::OP_W-1:0]  opcode;
  logic [obl_pkg::ADDR_W-1:0] block_start;
  logic [obl_pkg::ADDR_W-1:0] block_end;

  modport source (output valid, opcode, block_start, block_end, input ready);
  modport sink   (input valid, opcode, block_start, block_end, output ready);
endinterface

interface obl_out_if #(parameter int CNT_W = 7);
  logic                       valid;
  logic                       ready;
  logic [obl_pkg::STAT_W-1:0] status;
  logic [obl_pkg::ADDR_W-1:0] removed_start;
  logic [obl_pkg::ADDR_W-1:0] removed_end;
  logic [CNT_W-1:0]           entry_count;

  modport source (output valid, status, removed_start, removed_end, entry_count,
                  input ready);
  modport sink   (input valid, status, removed_start, removed_end, entry_count,
                  output ready);
endinterface

// ===== hdl/obl_mem.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on obl_pkg for the entry width.
module obl_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [obl_pkg::ENT_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic [obl_pkg::ENT_W-1:0] rd_data
);
  import obl_pkg::*;

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/ordered_block_list_with_coalescing.sv =====
// Ordered block list with coalescing: sequencer around the entry store.
// Depends on obl_pkg, obl_if.sv and obl_mem.
//
// Usage: one command beat on in_ch (opcode, block_start, block_end) yields
// exactly one result beat on out_ch (status, removed block, entry count).
// Blocks live in a single-port-read, single-port-write memory, one entry
// per address, kept in list order. Every pass walks it one entry a cycle.
// Clear, full or empty rejects and a coalesce of under two entries go
// straight to the result; add back and any insert into an empty list
// write the entry directly; add front shifts every entry up one slot;
// remove front and coalesce walk the whole list; insert by address or
// size searches, then shifts the entries from its slot up unless it
// lands at the back.
// Commands are taken one at a time; in_ch.ready is high only while the
// sequencer is idle. The result sits in an output register, so the next
// command is accepted while an earlier result still waits for out_ch.ready;
// a finished command holds in its final state until that register frees.
// Reset empties the list (count to zero); the memory is not swept, since
// entries at or above the count are never used.
module ordered_block_list_with_coalescing #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  obl_in_if.sink     in_ch,
  obl_out_if.source  out_ch
);
  import obl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_PLACE  = 7'b0001000,
    S_RMV    = 7'b0010000,
    S_MRG    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  opcode_t         op_r, op_nxt;
  addr_t           s_r, s_nxt, e_r, e_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   ra_r, ra_nxt;
  logic [AW-1:0]   w_r, w_nxt;
  addr_t           cur_s_r, cur_s_nxt, cur_e_r, cur_e_nxt;
  status_t         st_r, st_nxt;
  addr_t           rs_r, rs_nxt, re_r, re_nxt;

  logic            out_valid_r, out_valid_nxt;
  status_t         out_st_r, out_st_nxt;
  addr_t           out_rs_r, out_rs_nxt, out_re_r, out_re_nxt;
  logic [CW-1:0]   out_cnt_r, out_cnt_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [ENT_W-1:0] wr_data, rd_data;
  addr_t           ds, de;
  logic signed [ADDR_W+1:0] sz_new, sz_ent;
  logic            stop;
  opcode_t         in_op;

  obl_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ds    = rd_data[ENT_W-1:ADDR_W];
  assign de    = rd_data[ADDR_W-1:0];
  assign in_op = opcode_t'(in_ch.opcode);

  // size - 1, compared as signed
  assign sz_new = $signed({2'b00, e_r}) - $signed({2'b00, s_r});
  assign sz_ent = $signed({2'b00, de}) - $signed({2'b00, ds});

  always_comb begin
    case (op_r)
      OP_INS_ADDR: stop = !(s_r > ds);
      OP_INS_ASC:  stop = sz_new < sz_ent;
      OP_INS_DESC: stop = sz_new > sz_ent;
      default:     stop = 1'b1;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    s_nxt     = s_r;
    e_nxt     = e_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    ra_nxt    = ra_r;
    w_nxt     = w_r;
    cur_s_nxt = cur_s_r;
    cur_e_nxt = cur_e_r;
    st_nxt    = st_r;
    rs_nxt    = rs_r;
    re_nxt    = re_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_addr   = '0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_rs_nxt    = out_rs_r;
    out_re_nxt    = out_re_r;
    out_cnt_nxt   = out_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_op;
          s_nxt    = in_ch.block_start;
          e_nxt    = in_ch.block_end;
          st_nxt   = ST_OK;
          rs_nxt   = '0;
          re_nxt   = '0;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          w_nxt    = '0;
          case (in_op)
            OP_ADD_FRONT, OP_ADD_BACK, OP_INS_ADDR, OP_INS_ASC, OP_INS_DESC: begin
              if (cnt_r == FULL_CNT) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else if (in_op == OP_ADD_FRONT) begin
                pos_nxt   = '0;
                idx_nxt   = cnt_r;
                state_nxt = S_SHIFT;
              end else if (in_op == OP_ADD_BACK || cnt_r == '0) begin
                pos_nxt   = (in_op == OP_ADD_BACK) ? cnt_r : '0;
                state_nxt = S_PLACE;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            OP_REMOVE: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RMV;
              end
            end
            OP_COALESCE: begin
              state_nxt = (cnt_r < CW'(2)) ? S_DONE : S_MRG;
            end
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        rd_addr = idx_r[AW-1:0];
        if (idx_r < cnt_r) begin
          pend_nxt = 1'b1;
          ra_nxt   = idx_r[AW-1:0];
          idx_nxt  = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && stop) begin
          pos_nxt   = CW'(ra_r);
          idx_nxt   = cnt_r;
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else if (!pend_r && idx_r != '0) begin
          pos_nxt   = cnt_r;
          state_nxt = S_PLACE;
        end
      end

      S_SHIFT: begin
        // move entries up one slot, top first
        rd_addr = AW'(idx_r - CW'(1));
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = ra_r + AW'(1);
          wr_data = rd_data;
        end
        if (idx_r > pos_r) begin
          pend_nxt = 1'b1;
          ra_nxt   = AW'(idx_r - CW'(1));
          idx_nxt  = idx_r - CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[AW-1:0];
        wr_data   = {s_r, e_r};
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_RMV: begin
        rd_addr = idx_r[AW-1:0];
        if (idx_r < cnt_r) begin
          pend_nxt = 1'b1;
          ra_nxt   = idx_r[AW-1:0];
          idx_nxt  = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (ra_r == '0) begin
            rs_nxt = ds;
            re_nxt = de;
          end else begin
            wr_en   = 1'b1;
            wr_addr = ra_r - AW'(1);
            wr_data = rd_data;
          end
        end else if (idx_r != '0) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_MRG: begin
        // stream entries through the current block, compacting behind the read
        rd_addr = idx_r[AW-1:0];
        if (idx_r < cnt_r) begin
          pend_nxt = 1'b1;
          ra_nxt   = idx_r[AW-1:0];
          idx_nxt  = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (ra_r == '0) begin
            cur_s_nxt = ds;
            cur_e_nxt = de;
          end else if ({1'b0, cur_e_r} + (ADDR_W+1)'(1) == {1'b0, ds}) begin
            cur_e_nxt = de;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = w_r;
            wr_data   = {cur_s_r, cur_e_r};
            w_nxt     = w_r + AW'(1);
            cur_s_nxt = ds;
            cur_e_nxt = de;
          end
        end else if (idx_r != '0) begin
          wr_en     = 1'b1;
          wr_addr   = w_r;
          wr_data   = {cur_s_r, cur_e_r};
          cnt_nxt   = CW'(w_r) + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_rs_nxt    = rs_r;
          out_re_nxt    = re_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    ra_r      <= ra_nxt;
    w_r       <= w_nxt;
    cur_s_r   <= cur_s_nxt;
    cur_e_r   <= cur_e_nxt;
    st_r      <= st_nxt;
    rs_r      <= rs_nxt;
    re_r      <= re_nxt;
    out_st_r  <= out_st_nxt;
    out_rs_r  <= out_rs_nxt;
    out_re_r  <= out_re_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.removed_start = out_rs_r;
  assign out_ch.removed_end   = out_re_r;
  assign out_ch.entry_count   = out_cnt_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count beyond table depth");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r == ST_FULL |-> out_cnt_r == FULL_CNT)
    else $error("full status reported with room left");

  a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE || state_r == S_DONE |-> !wr_en)
    else $error("memory written outside a pass");

  a_rm_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r == ST_EMPTY |-> out_cnt_r == '0 && out_rs_r == '0)
    else $error("empty status with blocks held");
`endif

endmodule

// ===== dv/obl_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench copy of nothing: interfaces come from hdl/obl_if.sv.
// This file holds a small helper package of testbench types; depends on obl_pkg.
package obl_tb_pkg;
  import obl_pkg::*;

  typedef struct packed {
    opcode_t opcode;
    addr_t   block_start;
    addr_t   block_end;
  } cmd_beat_t;

  typedef struct packed {
    status_t    status;
    addr_t      removed_start;
    addr_t      removed_end;
    logic [6:0] entry_count;
  } result_beat_t;
endpackage

// ===== dv/ordered_block_list_with_coalescing_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the ordered block list: random and directed commands, each
// result checked against an in-bench model of the ordered table with merging.
module ordered_block_list_with_coalescing_tb;
  import obl_pkg::*;
  import obl_tb_pkg::*;

  localparam int DEPTH = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  obl_in_if  in_ch ();
  obl_out_if #(.CNT_W(7)) out_ch ();

  ordered_block_list_with_coalescing #(.TABLE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cmd_beat_t    cmd_q[$];
  result_beat_t want_q[$];
  bit           failed = 1'b0;
  bit           calm = 1'b0;

  // table shadow
  addr_t  tbl_start[DEPTH];
  addr_t  tbl_end[DEPTH];
  int     held = 0;

  function automatic longint blk_len(addr_t s, addr_t e);
    return longint'(e) - longint'(s) + 1;
  endfunction

  function automatic void shadow_put(int pos, addr_t s, addr_t e);
    for (int i = held; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_end[i]   = tbl_end[i-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos]   = e;
    held++;
  endfunction

  function automatic void shadow_drop(int pos);
    for (int i = pos; i + 1 < held; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_end[i]   = tbl_end[i+1];
    end
    held--;
  endfunction

  function automatic result_beat_t apply_cmd(cmd_beat_t c);
    result_beat_t r;
    int pos;
    longint sz;
    r = '0;
    r.status = ST_OK;
    pos = 0;
    sz = blk_len(c.block_start, c.block_end);
    case (c.opcode)
      OP_ADD_FRONT, OP_ADD_BACK, OP_INS_ADDR, OP_INS_ASC, OP_INS_DESC: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          case (c.opcode)
            OP_ADD_BACK: pos = held;
            OP_INS_ADDR:
              while (pos < held && c.block_start > tbl_start[pos]) pos++;
            OP_INS_ASC:
              while (pos < held && !(sz < blk_len(tbl_start[pos], tbl_end[pos]))) pos++;
            OP_INS_DESC:
              while (pos < held && !(sz > blk_len(tbl_start[pos], tbl_end[pos]))) pos++;
            default: pos = 0;
          endcase
          shadow_put(pos, c.block_start, c.block_end);
        end
      end
      OP_REMOVE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_start = tbl_start[0];
          r.removed_end   = tbl_end[0];
          shadow_drop(0);
        end
      end
      OP_COALESCE: begin
        // merge chains in place; top address never wraps
        while (pos + 1 < held) begin
          if ({1'b0, tbl_end[pos]} + 32'd1 == {1'b0, tbl_start[pos+1]}) begin
            tbl_end[pos] = tbl_end[pos+1];
            shadow_drop(pos + 1);
          end else begin
            pos++;
          end
        end
      end
      default: held = 0;
    endcase
    r.entry_count = held[6:0];
    return r;
  endfunction

  function automatic addr_t rand_addr();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return addr_t'($urandom_range(0, 300));
      default: return addr_t'($urandom);
    endcase
  endfunction

  function automatic void push_cmd(opcode_t op, addr_t s, addr_t e);
    cmd_beat_t c;
    c.opcode = op;
    c.block_start = s;
    c.block_end = e;
    cmd_q.push_back(c);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= OP_ADD_FRONT;
      in_ch.block_start <= '0;
      in_ch.block_end <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd_beat_t c;
        c.opcode = opcode_t'(in_ch.opcode);
        c.block_start = in_ch.block_start;
        c.block_end = in_ch.block_end;
        want_q.push_back(apply_cmd(c));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
          cmd_beat_t n;
          n = cmd_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= n.opcode;
          in_ch.block_start <= n.block_start;
          in_ch.block_end <= n.block_end;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d count=%0d", $time,
                   out_ch.status, out_ch.entry_count);
          failed = 1'b1;
        end else begin
          result_beat_t w;
          w = want_q.pop_front();
          if (out_ch.status !== w.status)
            begin $display("%0t: status exp %0d got %0d", $time, w.status, out_ch.status);
            failed = 1'b1; end
          if (out_ch.removed_start !== w.removed_start)
            begin $display("%0t: removed_start exp %h got %h", $time, w.removed_start,
                     out_ch.removed_start); failed = 1'b1; end
          if (out_ch.removed_end !== w.removed_end)
            begin $display("%0t: removed_end exp %h got %h", $time, w.removed_end,
                     out_ch.removed_end); failed = 1'b1; end
          if (out_ch.entry_count !== w.entry_count)
            begin $display("%0t: entry_count exp %0d got %0d", $time, w.entry_count,
                     out_ch.entry_count); failed = 1'b1; end
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    int n;
    opcode_t op;
    addr_t s;
    // directed: empty remove, extremes, every op, merges, top address, end < start
    push_cmd(OP_REMOVE, '1, '1);
    push_cmd(OP_COALESCE, '0, '0);
    push_cmd(OP_ADD_BACK, 31'd10, 31'd19);
    push_cmd(OP_ADD_BACK, 31'd20, 31'd29);
    push_cmd(OP_ADD_BACK, 31'd30, 31'd5);
    push_cmd(OP_ADD_BACK, 31'd6, 31'd6);
    push_cmd(OP_ADD_FRONT, 31'h7FFFFFF0, '1);
    push_cmd(OP_ADD_BACK, '0, '0);
    push_cmd(OP_INS_ADDR, 31'd15, 31'd15);
    push_cmd(OP_INS_ASC, 31'd100, 31'd109);
    push_cmd(OP_INS_DESC, 31'd200, 31'd209);
    push_cmd(OP_INS_ASC, 31'd50, 31'd40);
    push_cmd(OP_INS_DESC, '1, '0);
    push_cmd(OP_COALESCE, '1, '1);
    push_cmd(OP_REMOVE, '0, '0);
    push_cmd(OP_REMOVE, '0, '0);
    push_cmd(OP_CLEAR, '1, '0);
    push_cmd(OP_REMOVE, '0, '0);
    // fill to full and overflow add front, insert by address and insert descending
    for (int i = 0; i < DEPTH; i++) push_cmd(OP_ADD_BACK, addr_t'(i*4), addr_t'(i*4+3));
    push_cmd(OP_ADD_FRONT, '1, '1);
    push_cmd(OP_INS_ADDR, '1, '1);
    push_cmd(OP_INS_DESC, '1, '1);
    push_cmd(OP_COALESCE, '0, '0);
    push_cmd(OP_CLEAR, '0, '0);
    // random: bursts of adjacent blocks so coalesce has work, plus noise
    n = 0;
    while (n < 1350) begin
      if ($urandom_range(0, 3) == 0) begin
        s = addr_t'($urandom_range(0, 2000));
        repeat ($urandom_range(2, 6)) begin
          addr_t e;
          e = s + addr_t'($urandom_range(0, 7));
          push_cmd(opcode_t'($urandom_range(0, 4)), s, e);
          s = e + addr_t'(1);
          n++;
        end
        push_cmd(OP_COALESCE, rand_addr(), rand_addr());
        n++;
      end else begin
        case ($urandom_range(0, 19))
          0:      op = OP_CLEAR;
          1, 2:   op = OP_COALESCE;
          3, 4, 5, 6: op = OP_REMOVE;
          default: op = opcode_t'($urandom_range(0, 4));
        endcase
        push_cmd(op, rand_addr(), rand_addr());
        n++;
      end
      // occasionally run a full-table stretch
      if ($urandom_range(0, 199) == 0)
        repeat (DEPTH + 2) begin
          push_cmd(opcode_t'($urandom_range(0, 4)), rand_addr(), rand_addr());
          n++;
        end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        wait (cmd_q.size() < 900);
        calm = 1'b1;
        wait (cmd_q.size() < 600);
        calm = 1'b0;
      end
    join_none
    wait (cmd_q.size() == 0);
    @(posedge clk);
    while (in_ch.valid || want_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/obl_pkg.sv
hdl/obl_if.sv
hdl/obl_mem.sv
hdl/ordered_block_list_with_coalescing.sv
dv/obl_tb_if.sv
dv/ordered_block_list_with_coalescing_tb.sv
